>>> rtl/sinusoidal_position_encoding_adder_defines.svh
// Assertion helpers for the checker file.
`ifndef SINUSOIDAL_POSITION_ENCODING_ADDER_DEFINES_SVH
`define SINUSOIDAL_POSITION_ENCODING_ADDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SPE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spe_pkg.sv
package spe_pkg;

  // Stream widths.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 16;

  // One frequency entry per dimension pair that a 9-bit column can address.
  localparam int NUM_PAIRS = 256;

  localparam logic [15:0] MAX_POS_RESET = 16'd2048;

  localparam longint unsigned LOG2_1E4_Q32 = 64'd57070290109;
  localparam longint unsigned INV2PI_Q32   = 64'd683565276;

  // Quadrant codes taken from the top two bits of the phase.
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // Per-item bookkeeping that rides along the CORDIC chain.
  typedef struct packed {
    logic signed [15:0] value;
    logic               odd;
    logic               enc;
    logic               beyond;
    logic [1:0]         quad;
  } tag_t;

  // CORDIC vector, x and y in Q2.30, z in turns Q0.32.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // Integer square root, bit by bit.
  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bit_v;
    rem   = v;
    res   = 64'd0;
    bit_v = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Restoring division for elaboration-time tables.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Frequency of pair k in turns per position, Q0.32.
  function automatic logic [31:0] pair_freq(input int unsigned k,
                                            input int unsigned dmodel);
    longint unsigned e;
    longint unsigned n;
    longint unsigned r;
    longint unsigned m;
    longint unsigned c;
    longint unsigned f;
    e = udiv64(64'd2 * 64'(k) * LOG2_1E4_Q32 + (64'(dmodel) >> 1), 64'(dmodel));
    n = e >> 32;
    r = e & 64'hffff_ffff;
    m = 64'd1 << 32;
    c = 64'd1 << 31;
    for (int i = 1; i <= 32; i++) begin
      c = isqrt64(c << 32);
      if (r[32 - i]) begin
        m = (m * c) >> 32;
      end
    end
    if (n > 64'd40) begin
      m = 64'd0;
    end else begin
      m = m >> n;
    end
    f = (m * INV2PI_Q32 + (64'd1 << 31)) >> 32;
    return f[31:0];
  endfunction

  // Arctangent of 2^-i in turns, Q0.32, from a truncated series.
  function automatic logic [31:0] atan_turns(input int unsigned i);
    longint acc;
    longint unsigned t;
    longint unsigned rad;
    longint unsigned res;
    int unsigned sh;
    acc = 64'sd0;
    if (i == 0) begin
      return 32'h2000_0000;
    end
    for (int unsigned j = 0; j <= 30; j++) begin
      sh = i * (2 * j + 1);
      if (sh <= 60) begin
        t = udiv64(64'd1 << (60 - sh), 64'(2 * j + 1));
        if (j[0]) begin
          acc = acc - longint'(t);
        end else begin
          acc = acc + longint'(t);
        end
      end
    end
    rad = longint'(acc + (64'sd1 <<< 27)) >> 28;
    res = (rad * INV2PI_Q32 + (64'd1 << 31)) >> 32;
    return res[31:0];
  endfunction

  // Reciprocal of the CORDIC gain for a given number of iterations, Q2.30.
  function automatic logic [31:0] cordic_gain(input int unsigned steps);
    longint unsigned x;
    longint unsigned v;
    longint unsigned sq;
    x = 64'd1 << 30;
    for (int unsigned i = 0; i < 24; i++) begin
      if (i < steps) begin
        v  = (64'd1 << 30) + ((64'd1 << 30) >> (2 * i));
        sq = isqrt64(v << 30);
        x  = (x * udiv64(64'd1 << 60, sq)) >> 30;
      end
    end
    return x[31:0];
  endfunction

endpackage

>>> rtl/spe_phase.sv
module spe_phase #(
  parameter int D_MODEL      = 512,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        max_positions,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        position,
  input  logic [8:0]         dimension,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output spe_pkg::tag_t      out_tag,
  output spe_pkg::vec_t      out_vec
);

  localparam logic [31:0] GAIN = spe_pkg::cordic_gain(CORDIC_STEPS);

  // Frequency table, one entry per dimension pair, built at elaboration.
  logic [31:0] freq_rom [spe_pkg::NUM_PAIRS];

  for (genvar k = 0; k < spe_pkg::NUM_PAIRS; k++) begin : g_rom
    assign freq_rom[k] = spe_pkg::pair_freq(k, D_MODEL);
  end

  // First stage: table read and range checks.
  logic          a_valid;
  logic          a_ready;
  logic [15:0]   a_pos;
  logic [31:0]   a_freq;
  spe_pkg::tag_t a_tag;
  spe_pkg::tag_t tag_next;

  logic [47:0] prod;
  logic [31:0] phase;

  spe_pkg::tag_t tag_start;
  spe_pkg::vec_t vec_start;

  always_comb begin
    tag_next.value  = value;
    tag_next.odd    = dimension[0];
    tag_next.beyond = (position >= max_positions);
    tag_next.enc    = !tag_next.beyond && (32'(dimension) < 32'(D_MODEL));
    tag_next.quad   = spe_pkg::QUAD_I;
  end

  assign in_ready = !a_valid || a_ready;
  assign a_ready  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_pos  <= position;
      a_freq <= freq_rom[dimension[8:1]];
      a_tag  <= tag_next;
    end
  end

  // Second stage: phase in turns, modulo one turn.
  assign prod  = 48'(a_pos) * 48'(a_freq);
  assign phase = prod[31:0];

  // The top two phase bits pick the quadrant; the rest is the CORDIC angle.
  always_comb begin
    tag_start      = a_tag;
    tag_start.quad = phase[31:30];
    vec_start.x    = $signed(GAIN);
    vec_start.y    = 32'sd0;
    vec_start.z    = $signed({2'b00, phase[29:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      out_tag <= tag_start;
      out_vec <= vec_start;
    end
  end

endmodule

>>> rtl/spe_cordic_cell.sv
module spe_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spe_pkg::tag_t in_tag,
  input  spe_pkg::vec_t in_vec,
  output logic          out_valid,
  input  logic          out_ready,
  output spe_pkg::tag_t out_tag,
  output spe_pkg::vec_t out_vec
);

  localparam logic signed [31:0] ATAN = $signed(spe_pkg::atan_turns(STEP));

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  spe_pkg::vec_t      vec_next;

  // One micro-rotation; the sign of the residual angle picks the direction.
  always_comb begin
    dx = $signed(in_vec.y) >>> STEP;
    dy = $signed(in_vec.x) >>> STEP;
    if (!in_vec.z[31]) begin
      vec_next.x = $signed(in_vec.x) - dx;
      vec_next.y = $signed(in_vec.y) + dy;
      vec_next.z = $signed(in_vec.z) - ATAN;
    end else begin
      vec_next.x = $signed(in_vec.x) + dx;
      vec_next.y = $signed(in_vec.y) - dy;
      vec_next.z = $signed(in_vec.z) + ATAN;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_tag <= in_tag;
      out_vec <= vec_next;
    end
  end

endmodule

>>> rtl/spe_output.sv
module spe_output (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spe_pkg::tag_t      in_tag,
  input  spe_pkg::vec_t      in_vec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sum,
  output logic               beyond_limit
);

  logic signed [31:0] sin_v;
  logic signed [31:0] cos_v;
  logic signed [31:0] enc;
  logic signed [31:0] rnd;
  logic signed [12:0] enc_q;
  logic signed [16:0] wide;
  logic signed [15:0] sum_next;

  // Fold the first-quadrant result back to the full circle.
  always_comb begin
    case (in_tag.quad)
      spe_pkg::QUAD_I: begin
        sin_v = in_vec.y;
        cos_v = in_vec.x;
      end
      spe_pkg::QUAD_II: begin
        sin_v = in_vec.x;
        cos_v = -$signed(in_vec.y);
      end
      spe_pkg::QUAD_III: begin
        sin_v = -$signed(in_vec.y);
        cos_v = -$signed(in_vec.x);
      end
      default: begin
        sin_v = -$signed(in_vec.x);
        cos_v = in_vec.y;
      end
    endcase
  end

  // Round half up from Q2.30 to Q4.11, then add and saturate; an item without an encoding passes its value through.
  always_comb begin
    enc   = in_tag.odd ? cos_v : sin_v;
    rnd   = enc + 32'sd262144;
    enc_q = rnd[31:19];
    wide  = 17'(in_tag.value) + 17'(enc_q);
    if (!in_tag.enc) begin
      sum_next = in_tag.value;
    end else if (wide > 17'sd32767) begin
      sum_next = 16'sh7fff;
    end else if (wide < -17'sd32768) begin
      sum_next = 16'sh8000;
    end else begin
      sum_next = wide[15:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sum          <= sum_next;
      beyond_limit <= in_tag.beyond;
    end
  end

endmodule

>>> rtl/sinusoidal_position_encoding_adder.sv
// Sinusoidal position encoding adder.
// Input stream (s_axis): one transaction per embedding element, carrying the
// sequence position, the embedding column and the Q4.11 value. Output stream
// (m_axis): one transaction per input, carrying the value plus the sine
// (even column) or cosine (odd column) encoding, saturated to 16 bits, and in
// tuser a flag that is set when the position is not below max_positions, in
// which case the value passes through unchanged.
// The block takes one transaction per cycle while m_axis_tready stays high.
// The item passes CORDIC_STEPS + 3 register stages: the frequency table read,
// loaded at the accepting edge, the position by frequency multiply, one per
// CORDIC cell, and rounding, add and saturation. Every stage holds one item,
// and the chain of CORDIC cells sets the latency. Reset clears all valid flags
// and loads max_positions with 2048; it is to be written by the user through
// cfg_we and cfg_wdata only while the block is idle, which the block itself
// does not enforce.
// When the receiver stalls, the output holds its transaction and the stages
// behind it keep filling any empty slots, so s_axis_tready drops only once
// every stage holds an item.
module sinusoidal_position_encoding_adder #(
  parameter int D_MODEL      = 512,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: max_positions.
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] position, [24:16] dimension, [40:25] value, [47:41] zero
  input  logic [spe_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] sum
  output logic [spe_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] beyond_limit
  output logic                          m_axis_tuser
);

  logic [15:0] max_positions;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_positions <= spe_pkg::MAX_POS_RESET;
    end else if (cfg_we) begin
      max_positions <= cfg_wdata;
    end
  end

  // Handshake and payload between consecutive stages; index 0 is the
  // phase stage output, index CORDIC_STEPS feeds the output stage.
  logic          valid [CORDIC_STEPS+1];
  logic          ready [CORDIC_STEPS+1];
  spe_pkg::tag_t tag   [CORDIC_STEPS+1];
  spe_pkg::vec_t vec   [CORDIC_STEPS+1];

  logic signed [15:0] sum;

  spe_phase #(
    .D_MODEL      (D_MODEL),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_phase (
    .clk           (clk),
    .rst           (rst),
    .max_positions (max_positions),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .position      (s_axis_tdata[15:0]),
    .dimension     (s_axis_tdata[24:16]),
    .value         ($signed(s_axis_tdata[40:25])),
    .out_valid     (valid[0]),
    .out_ready     (ready[0]),
    .out_tag       (tag[0]),
    .out_vec       (vec[0])
  );

  // One cell per CORDIC iteration; each hands its vector to the next.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    spe_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_tag    (tag[i]),
      .in_vec    (vec[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_tag   (tag[i+1]),
      .out_vec   (vec[i+1])
    );
  end

  spe_output u_output (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (valid[CORDIC_STEPS]),
    .in_ready     (ready[CORDIC_STEPS]),
    .in_tag       (tag[CORDIC_STEPS]),
    .in_vec       (vec[CORDIC_STEPS]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .sum          (sum),
    .beyond_limit (m_axis_tuser)
  );

  assign m_axis_tdata = sum;

endmodule

>>> rtl/spe_checker.sv
`include "sinusoidal_position_encoding_adder_defines.svh"

module spe_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [spe_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  localparam int DEPTH = CORDIC_STEPS + 3;
  localparam int CW    = $clog2(DEPTH + 2);

  logic          in_acc;
  logic          out_acc;
  logic [CW-1:0] count;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Items accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc && !out_acc) begin
      count <= count + 1'b1;
    end else if (!in_acc && out_acc) begin
      count <= count - 1'b1;
    end
  end

  `SPE_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output changed")
  `SPE_ASSERT_IMPL(a_no_orphan, clk, rst, m_axis_tvalid, count != '0, "result without an accepted item")
  `SPE_ASSERT_IMPL(a_depth, clk, rst, 1'b1, count <= CW'(DEPTH), "more items in flight than stages")
  `SPE_ASSERT_IMPL(a_flow, clk, rst, m_axis_tready, s_axis_tready, "input stalled while output drains")

endmodule

bind sinusoidal_position_encoding_adder spe_checker #(
  .CORDIC_STEPS (CORDIC_STEPS)
) u_spe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  // Block configuration as built. Every 9-bit column falls inside the
  // 512-wide embedding, so each column gets an encoding when its position is below the limit.
  localparam int unsigned PAIRS       = 256;
  localparam int unsigned EMB_DIM     = 512;
  localparam int unsigned ROT_STEPS   = 16;
  localparam logic [15:0] RESET_LIMIT = 16'd2048;

  // log2(10000) and 1/(2*pi), both scaled by 2^32.
  localparam u64_t LOG2_TENK  = 64'd57070290109;
  localparam u64_t INV_TWO_PI = 64'd683565276;

  // The settle time at the end gives any stray result time to come out.
  localparam int SETTLE_CYCLES     = 40;
  localparam int SINK_STALL_CYCLES = 400;

  // One result transaction: tdata carries the sum, tuser the limit flag.
  typedef struct packed {
    logic signed [15:0] sum;
    logic               beyond;
  } encoded_sum_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [spe_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [spe_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tuser;

  // Predictor state: the frequency per dimension pair, the arctangent of
  // each CORDIC step in turns, the CORDIC start value and the limit register.
  logic [31:0] pair_rate [PAIRS];
  s64_t        atan_step [ROT_STEPS];
  s64_t        rot_gain;
  logic [15:0] cfg_max_pos = RESET_LIMIT;

  // Sums that have been predicted but not yet seen on the output, oldest first.
  encoded_sum_t sums_due[$];
  int           err_count = 0;

  // Sender and receiver pacing. With the steady flags set the side never
  // idles. A stall request makes the receiver hold tready low for a long
  // stretch that it counts itself.
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;
  int stall_requests = 0;
  int stall_taken    = 0;
  int stall_left     = 0;

  always #5 clk = ~clk;

  sinusoidal_position_encoding_adder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bitwise integer square root, floor of sqrt(v).
  function automatic u64_t int_sqrt(input u64_t v);
    u64_t rem, root, probe;
    rem   = v;
    root  = 64'd0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Turns per position for pair k, Q0.32. The exponent 2k*log2(10000)/D is
  // split into an integer shift and a fraction; 2^-fraction is built from
  // repeated square roots of one half, one factor per set fraction bit.
  function automatic logic [31:0] pair_turn_rate(input int unsigned k);
    u64_t        expo, mant, cval, rate;
    int unsigned whole;
    logic [31:0] frac;
    expo  = (64'd2 * k * LOG2_TENK + u64_t'(EMB_DIM / 2)) / u64_t'(EMB_DIM);
    whole = int'(expo >> 32);
    frac  = expo[31:0];
    mant  = 64'd1 << 32;
    cval  = 64'd1 << 31;
    for (int i = 1; i <= 32; i++) begin
      cval = int_sqrt(cval << 32);
      if (frac[32 - i]) mant = (mant * cval) >> 32;
    end
    mant = (whole > 40) ? 64'd0 : (mant >> whole);
    rate = (mant * INV_TWO_PI + (64'd1 << 31)) >> 32;
    return rate[31:0];
  endfunction

  // arctan(2^-i) in turns, Q0.32, from the Taylor series cut at 2^-60.
  function automatic s64_t atan_turn(input int unsigned i);
    s64_t        acc, term, rad;
    u64_t        prod;
    int unsigned sh;
    if (i == 0) return 64'sh2000_0000;
    acc = 0;
    for (int unsigned j = 0; j < 64; j++) begin
      sh = i * (2 * j + 1);
      if (sh > 60) break;
      term = s64_t'((64'd1 << (60 - sh)) / u64_t'(2 * j + 1));
      acc  = (j % 2 == 1) ? acc - term : acc + term;
    end
    rad  = (acc + (64'sd1 <<< 27)) >>> 28;
    prod = (u64_t'(rad) * INV_TWO_PI + (64'd1 << 31)) >> 32;
    return s64_t'(prod);
  endfunction

  function automatic void build_tables();
    u64_t v, gain;
    for (int unsigned k = 0; k < PAIRS; k++) pair_rate[k] = pair_turn_rate(k);
    for (int unsigned i = 0; i < ROT_STEPS; i++) atan_step[i] = atan_turn(i);
    // The CORDIC starts from 1/gain so that its output needs no scaling.
    gain = 64'd1 << 30;
    for (int i = 0; i < ROT_STEPS; i++) begin
      v    = (64'd1 << 30) + ((64'd1 << 30) >> (2 * i));
      gain = (gain * ((64'd1 << 60) / int_sqrt(v << 30))) >> 30;
    end
    rot_gain = s64_t'(gain);
  endfunction

  // Sine (even column) or cosine (odd column) of position times the pair
  // frequency, in Q2.30. The top two phase bits pick the quadrant and the
  // CORDIC rotates through the remaining quarter turn.
  function automatic s64_t encoding_q30(input logic [15:0] pos, input logic [8:0] dim);
    logic [31:0] phase;
    s64_t        x, y, z, dx, dy, sn, cs;
    phase = pos * pair_rate[dim[8:1]];
    z     = s64_t'({34'd0, phase[29:0]});
    x     = rot_gain;
    y     = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_step[i];
      end
    end
    case (phase[31:30])
      spe_pkg::QUAD_I: begin
        sn = y;
        cs = x;
      end
      spe_pkg::QUAD_II: begin
        sn = x;
        cs = -y;
      end
      spe_pkg::QUAD_III: begin
        sn = -y;
        cs = -x;
      end
      default: begin
        sn = -x;
        cs = y;
      end
    endcase
    return dim[0] ? cs : sn;
  endfunction

  // Expected output for one element under the current limit register.
  function automatic encoded_sum_t predict_sum(input logic [15:0] pos, input logic [8:0] dim,
                                               input logic signed [15:0] val);
    encoded_sum_t r;
    s64_t         enc, total;
    r.sum    = val;
    r.beyond = 1'b0;
    if (pos >= cfg_max_pos) begin
      r.beyond = 1'b1;
    end else begin
      // Round half up from Q2.30 to Q4.11, then add and saturate.
      enc   = (encoding_q30(pos, dim) + (64'sd1 <<< 18)) >>> 19;
      total = s64_t'(val) + enc;
      if (total > 32767) total = 32767;
      else if (total < -32768) total = -32768;
      r.sum = total[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and result checking
  // ---------------------------------------------------------------------------

  // The receiver drops tready in about a quarter of the cycles unless it is
  // told to stay steady, and serves each stall request with one long hold.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_requests != stall_taken) begin
      stall_taken   <= stall_requests;
      stall_left    <= SINK_STALL_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= sink_steady || ($urandom_range(99) >= 25);
    end
  end

  // Every output transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    encoded_sum_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sums_due.size() == 0) begin
        $error("unexpected result transaction: sum %0d, beyond_limit %0b",
               $signed(m_axis_tdata), m_axis_tuser);
        err_count++;
      end else begin
        want = sums_due.pop_front();
        if (m_axis_tdata !== want.sum) begin
          $error("sum mismatch: expected %0d, actual %0d", want.sum, $signed(m_axis_tdata));
          err_count++;
        end
        if (m_axis_tuser !== want.beyond) begin
          $error("beyond_limit mismatch: expected %0b, actual %0b", want.beyond, m_axis_tuser);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and phase control
  // ---------------------------------------------------------------------------

  // Offers one element and returns at the edge where the transaction is
  // accepted, with tvalid still high so that back-to-back elements need no
  // gap. The prediction is queued at that same edge.
  task automatic send_item(input logic [15:0] pos, input logic [8:0] dim,
                           input logic signed [15:0] val);
    while (!src_steady && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, val, dim, pos};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sums_due.push_back(predict_sum(pos, dim, val));
  endtask

  // Random elements shaped around the current limit: most positions get an
  // encoding, some sit right at the limit and some span the whole field.
  // Values are mostly embedding-sized, with full-range and near-rail ones to
  // drive the saturation.
  task automatic send_random_items(input int count);
    logic [15:0]        pos;
    logic [8:0]         dim;
    logic signed [15:0] val;
    int unsigned        sel;
    repeat (count) begin
      sel = $urandom_range(9);
      if (cfg_max_pos != 0 && sel < 7) pos = 16'($urandom_range(cfg_max_pos - 1));
      else if (sel == 7) pos = cfg_max_pos + 16'($urandom_range(2)) - 16'd1;
      else pos = 16'($urandom);
      dim = 9'($urandom);
      sel = $urandom_range(9);
      if (sel < 6) val = 16'($urandom_range(8191)) - 16'd4096;
      else if (sel < 9) val = 16'($urandom);
      else if ($urandom_range(1) == 1) val = 16'sh7fff - 16'($urandom_range(2047));
      else val = 16'sh8000 + 16'($urandom_range(2047));
      send_item(pos, dim, val);
    end
  endtask

  // Stops offering and waits until every predicted sum has come out. Since
  // each element yields exactly one result the block is idle afterwards.
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sums_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_pos(input logic [15:0] limit);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_max_pos = limit;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset limit of 2048: every quadrant for sine and cosine, the field
  // extremes, saturation at both rails and positions at and past the limit.
  task automatic test_directed_cases();
    send_item(16'd0, 9'd0, 16'sd0);
    send_item(16'd0, 9'd1, 16'sd0);
    for (int p = 1; p <= 6; p++) send_item(16'(p), 9'd0, 16'sd0);
    send_item(16'd2, 9'd1, 16'sd0);
    send_item(16'd4, 9'd1, 16'sd0);
    send_item(16'd5, 9'd1, 16'sd0);
    send_item(16'd2047, 9'd511, 16'sh7fff);
    send_item(16'd2047, 9'd510, 16'sh8000);
    // cos(0) pushes the top value over the rail; sin of about 0.8 turn
    // pushes the bottom value under it.
    send_item(16'd0, 9'd1, 16'sh7fff);
    send_item(16'd5, 9'd0, 16'sh8000);
    send_item(16'd2048, 9'd0, 16'sd12345);
    send_item(16'd65535, 9'd511, -16'sd1);
    send_item(16'd1000, 9'd256, 16'sd1);
    send_item(16'd1234, 9'd2, -16'sd2048);
    drain_stream();
  endtask

  // Smallest, largest and zero limit, each probed right at its edge.
  task automatic test_limit_extremes();
    write_max_pos(16'd1);
    send_item(16'd0, 9'd3, 16'sd100);
    send_item(16'd1, 9'd3, 16'sd100);
    drain_stream();
    write_max_pos(16'd65535);
    send_item(16'd65534, 9'd0, 16'sd0);
    send_item(16'd65535, 9'd0, -16'sd5);
    drain_stream();
    // A zero limit leaves every position beyond it.
    write_max_pos(16'd0);
    send_item(16'd0, 9'd0, 16'sd7);
    send_item(16'd0, 9'd1, -16'sd7);
    drain_stream();
  endtask

  // Random traffic under a spread of limit settings with random idling.
  task automatic test_random_settings();
    logic [15:0] limits [5];
    limits = '{RESET_LIMIT, 16'd65535, 16'd1, 16'($urandom_range(64, 2)),
               16'($urandom_range(65535, 1))};
    foreach (limits[i]) begin
      write_max_pos(limits[i]);
      send_random_items(80);
      drain_stream();
    end
  endtask

  // A long stretch at full rate: neither side idles.
  task automatic test_unbroken_stream();
    write_max_pos(RESET_LIMIT);
    src_steady = 1'b1;
    sink_steady <= 1'b1;
    send_random_items(300);
    src_steady = 1'b0;
    sink_steady <= 1'b0;
    drain_stream();
  endtask

  // The receiver holds off long enough for every stage to fill, so the
  // input stalls while the sender keeps offering. Afterwards the sender
  // pauses until all results are out before it resumes.
  task automatic test_output_stall();
    stall_requests <= stall_requests + 1;
    src_steady = 1'b1;
    send_random_items(100);
    src_steady = 1'b0;
    drain_stream();
    send_random_items(40);
    drain_stream();
  endtask

  // Bulk random traffic, changing the limit between blocks.
  task automatic test_random_long();
    repeat (4) begin
      if ($urandom_range(3) == 0) write_max_pos(16'($urandom_range(65535, 1)));
      else write_max_pos(16'($urandom_range(4096, 16)));
      send_random_items(120);
      drain_stream();
    end
  endtask

  initial begin
    build_tables();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_limit_extremes();
    test_random_settings();
    test_unbroken_stream();
    test_output_stall();
    test_random_long();
    // Any stray transaction after the last expected one shows up here.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // A hung handshake or a missing result ends the run here.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
